// File: sv/pif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pif_pkg
// Types, character codes and helpers shared by the integer formatter modules.
// ----------------------------------------------------------------------------
package pif_pkg;

	localparam int FW       = 7;
	localparam int NDIG     = 22;
	localparam int DIGW     = 4 * NDIG;
	localparam int NSEG     = 8;
	localparam int SEGW     = 3;
	localparam int DCW      = 5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UL    = 8'h4C;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_X     = 8'h78;

	localparam logic [127:0] HEX_UPPER = "0123456789ABCDEF";
	localparam logic [127:0] HEX_LOWER = "0123456789abcdef";
	localparam logic [15:0]  PFX_UPPER = "0X";
	localparam logic [15:0]  PFX_LOWER = "0x";

	localparam logic [2:0] LM_NONE = 3'd0;
	localparam logic [2:0] LM_H    = 3'd1;
	localparam logic [2:0] LM_HH   = 3'd2;
	localparam logic [2:0] LM_L    = 3'd3;
	localparam logic [2:0] LM_LL   = 3'd4;

	localparam logic [SEGW-1:0] SEG_DIGITS = 3'd6;

	typedef enum logic [7:0] {
		PH_LIT    = 8'b0000_0001,
		PH_FLAGS  = 8'b0000_0010,
		PH_WDIG   = 8'b0000_0100,
		PH_AFTW   = 8'b0000_1000,
		PH_PSTART = 8'b0001_0000,
		PH_PDIG   = 8'b0010_0000,
		PH_AFTP   = 8'b0100_0000,
		PH_LEN    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic minus;
		logic zero;
		logic plus;
		logic space;
		logic hash;
	} spec_flags_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic conv;
		logic scan;
		logic plan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic dec_number;
		logic dec_decimal;
		logic conv_done;
		logic scan_done;
		logic emit_done;
	} sts_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [6:0] idx;
		idx = {4'd15 - nib, 3'b000};
		return upper ? HEX_UPPER[idx +: 8] : HEX_LOWER[idx +: 8];
	endfunction

endpackage

// File: sv/pif_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pif_ctrl
// Sequencer that steps one format item through decode, conversion and output.
// ----------------------------------------------------------------------------
module pif_ctrl import pif_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_CONV   = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_PLAN   = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_DECODE;
			end
			ST_DECODE: begin
				if (!sts.dec_number) state_n = ST_EMIT;
				else if (sts.dec_decimal) state_n = ST_CONV;
				else state_n = ST_SCAN;
			end
			ST_CONV: begin
				if (sts.conv_done) state_n = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_n = ST_PLAN;
			end
			ST_PLAN: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.emit_done) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.decode = (state_q == ST_DECODE);
	assign cmd.conv   = (state_q == ST_CONV);
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.plan   = (state_q == ST_PLAN);
	assign cmd.emit   = (state_q == ST_EMIT);

endmodule

// File: sv/pif_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pif_dp
// Format parser, binary to digit conversion and segmented character output.
// ----------------------------------------------------------------------------
module pif_dp import pif_pkg::*; #(
	parameter int MAX_FIELD = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  format_char,
	input  logic [63:0] arg_value,
	input  logic        end_of_format,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last,
	output logic [15:0] char_total
);

	phase_t          phase_q, phase_n;
	spec_flags_t     flags_q, flags_n;
	logic [FW-1:0]   width_q, width_n, prec_q, prec_n;
	logic            pg_q, pg_n;
	logic [2:0]      lm_q, lm_n;
	logic [15:0]     written_q;

	logic [7:0]      c_q;
	logic [63:0]     arg_q;
	logic            end_q;

	logic [63:0]     uv_q;
	logic            uvz_q, upper_q, base16_q;
	logic [7:0]      sign_q;
	logic [79:0]     bcd_q;
	logic [5:0]      conv_cnt_q;
	logic [DIGW-1:0] digs_q;
	logic [DCW-1:0]  dcnt_q;

	logic [SEGW-1:0] seg_q;
	logic [FW-1:0]   seg_cnt_q [NSEG];
	logic [7:0]      seg_char_q [NSEG];
	logic [FW-1:0]   rem_q;
	logic            endi_q;

	logic [FW-1:0]   seg_cnt_d [NSEG];
	logic [7:0]      seg_char_d [NSEG];
	logic [FW-1:0]   rem_d;

	function automatic logic [FW-1:0] add_digit(input logic [FW-1:0] acc,
		input logic [3:0] d);
		logic [9:0] v;
		v = 10'(acc) * 10'd10 + 10'(d);
		return (v > 10'(MAX_FIELD)) ? FW'(MAX_FIELD) : v[FW-1:0];
	endfunction

	function automatic logic [FW-1:0] star_mag(input logic [31:0] a);
		logic [31:0] m;
		m = a[31] ? (~a + 32'd1) : a;
		return (m > 32'(MAX_FIELD)) ? FW'(MAX_FIELD) : m[FW-1:0];
	endfunction

	// Decode of the held item.
	logic        is_end, isdig, is_len, do_conv, lit_out;
	logic [3:0]  dval;
	logic [2:0]  len_code;
	logic        c_num, c_signed, c_b16, c_b8, wide, sneg;
	logic [63:0] sv, uv_d;
	logic [7:0]  sign_d;
	logic [65:0] uv66;
	logic [DIGW-1:0] digs_d;
	logic [FW-1:0] cpad;

	always_comb begin
		is_end   = end_q || (c_q == CH_NUL);
		isdig    = (c_q >= CH_ZERO) && (c_q <= CH_NINE);
		dval     = 4'(c_q - CH_ZERO);
		len_code = LM_NONE;
		if (c_q == CH_H) len_code = LM_H;
		else if (c_q == CH_L) len_code = LM_L;
		else if (c_q == CH_UL) len_code = LM_LL;
		is_len   = (len_code != LM_NONE);

		phase_n = phase_q;
		flags_n = flags_q;
		width_n = width_q;
		prec_n  = prec_q;
		pg_n    = pg_q;
		lm_n    = lm_q;
		do_conv = 1'b0;
		lit_out = 1'b0;

		case (phase_q)
			PH_LIT: begin
				if (c_q == CH_PCT) phase_n = PH_FLAGS;
				else lit_out = 1'b1;
			end
			PH_FLAGS: begin
				if (c_q == CH_MINUS) flags_n.minus = 1'b1;
				else if (c_q == CH_ZERO) flags_n.zero = 1'b1;
				else if (c_q == CH_PLUS) flags_n.plus = 1'b1;
				else if (c_q == CH_SP) flags_n.space = 1'b1;
				else if (c_q == CH_HASH) flags_n.hash = 1'b1;
				else if (c_q == CH_STAR) begin
					width_n = star_mag(arg_q[31:0]);
					if (arg_q[31]) flags_n.minus = 1'b1;
					phase_n = PH_AFTW;
				end else if (isdig) begin
					width_n = add_digit('0, dval);
					phase_n = PH_WDIG;
				end else if (c_q == CH_DOT) begin
					pg_n = 1'b1;
					prec_n = '0;
					phase_n = PH_PSTART;
				end else if (is_len) begin
					lm_n = len_code;
					phase_n = PH_LEN;
				end else do_conv = 1'b1;
			end
			PH_WDIG, PH_AFTW: begin
				if (phase_q == PH_WDIG && isdig) width_n = add_digit(width_q, dval);
				else if (c_q == CH_DOT) begin
					pg_n = 1'b1;
					prec_n = '0;
					phase_n = PH_PSTART;
				end else if (is_len) begin
					lm_n = len_code;
					phase_n = PH_LEN;
				end else do_conv = 1'b1;
			end
			PH_PSTART, PH_PDIG: begin
				if (phase_q == PH_PSTART && c_q == CH_STAR) begin
					if (arg_q[31]) begin
						pg_n = 1'b0;
						prec_n = '0;
					end else prec_n = star_mag(arg_q[31:0]);
					phase_n = PH_AFTP;
				end else if (isdig) begin
					prec_n = add_digit(prec_q, dval);
					phase_n = PH_PDIG;
				end else if (is_len) begin
					lm_n = len_code;
					phase_n = PH_LEN;
				end else do_conv = 1'b1;
			end
			PH_AFTP: begin
				if (is_len) begin
					lm_n = len_code;
					phase_n = PH_LEN;
				end else do_conv = 1'b1;
			end
			PH_LEN: begin
				if (lm_q == LM_H && c_q == CH_H) lm_n = LM_HH;
				else if (lm_q == LM_L && c_q == CH_L) lm_n = LM_LL;
				else do_conv = 1'b1;
			end
			default: do_conv = 1'b1;
		endcase

		c_signed = (c_q == CH_D) || (c_q == CH_I);
		c_b16    = (c_q == CH_X) || (c_q == CH_UX) || (c_q == CH_P);
		c_b8     = (c_q == CH_O);
		c_num    = c_signed || c_b16 || c_b8 || (c_q == CH_U);
		wide     = (lm_q == LM_LL);

		sv     = wide ? arg_q : {{32{arg_q[31]}}, arg_q[31:0]};
		sneg   = c_signed && sv[63];
		sign_d = CH_NUL;
		if (c_q == CH_P) uv_d = {32'd0, arg_q[31:0]};
		else if (c_signed) uv_d = sneg ? (64'd0 - sv) : sv;
		else uv_d = wide ? arg_q : {32'd0, arg_q[31:0]};
		if (sneg) sign_d = CH_MINUS;
		else if (c_signed && flags_q.plus) sign_d = CH_PLUS;
		else if (c_signed && flags_q.space) sign_d = CH_SP;

		uv66 = {2'b00, uv_d};
		if (c_b16) digs_d = {24'd0, uv_d};
		else begin
			for (int i = 0; i < NDIG; i++) digs_d[4*i +: 4] = {1'b0, uv66[3*i +: 3]};
		end

		cpad = (width_q > FW'(1)) ? (width_q - FW'(1)) : '0;
	end

	// Output plan for the number, built once the digit count is known.
	logic [FW-1:0] dlen, numlen, zpad, ntotal, pad;
	logic          prelen, zfill;

	always_comb begin
		dlen   = (uvz_q && pg_q && prec_q == '0) ? '0 : FW'(dcnt_q);
		numlen = (pg_q && prec_q > dlen) ? prec_q : dlen;
		zpad   = numlen - dlen;
		prelen = flags_q.hash && base16_q && !uvz_q;
		ntotal = numlen + FW'(sign_q != CH_NUL) + (prelen ? FW'(2) : '0);
		pad    = (width_q > ntotal) ? (width_q - ntotal) : '0;
		zfill  = !flags_q.minus && flags_q.zero && !pg_q;
	end

	always_comb begin
		for (int i = 0; i < NSEG; i++) begin
			seg_cnt_d[i]  = '0;
			seg_char_d[i] = CH_SP;
		end
		rem_d = '0;
		if (cmd.plan) begin
			seg_cnt_d[0]  = (!flags_q.minus && !zfill) ? pad : '0;
			seg_char_d[1] = sign_q;
			seg_cnt_d[1]  = FW'(sign_q != CH_NUL);
			seg_char_d[2] = CH_ZERO;
			seg_cnt_d[2]  = FW'(prelen);
			seg_char_d[3] = upper_q ? PFX_UPPER[7:0] : PFX_LOWER[7:0];
			seg_cnt_d[3]  = FW'(prelen);
			seg_char_d[4] = CH_ZERO;
			seg_cnt_d[4]  = zfill ? pad : '0;
			seg_char_d[5] = CH_ZERO;
			seg_cnt_d[5]  = zpad;
			seg_cnt_d[6]  = dlen;
			seg_cnt_d[7]  = flags_q.minus ? pad : '0;
			rem_d         = pad + ntotal;
		end else if (is_end) begin
			seg_char_d[0] = CH_PCT;
			seg_cnt_d[0]  = FW'(phase_q != PH_LIT);
			seg_char_d[7] = CH_NUL;
			seg_cnt_d[7]  = FW'(1);
			rem_d         = seg_cnt_d[0] + FW'(1);
		end else if (lit_out) begin
			seg_char_d[0] = c_q;
			seg_cnt_d[0]  = FW'(1);
			rem_d         = FW'(1);
		end else if (do_conv && !c_num) begin
			if (c_q == CH_PCT) begin
				seg_char_d[0] = CH_PCT;
				seg_cnt_d[0]  = FW'(1);
				rem_d         = FW'(1);
			end else if (c_q == CH_C) begin
				seg_cnt_d[0]  = flags_q.minus ? '0 : cpad;
				seg_char_d[1] = arg_q[7:0];
				seg_cnt_d[1]  = FW'(1);
				seg_cnt_d[7]  = flags_q.minus ? cpad : '0;
				rem_d         = cpad + FW'(1);
			end else begin
				seg_char_d[0] = CH_PCT;
				seg_cnt_d[0]  = FW'(1);
				seg_char_d[1] = c_q;
				seg_cnt_d[1]  = FW'(1);
				rem_d         = FW'(2);
			end
		end
	end

	// Parse state.
	logic clear_spec;
	assign clear_spec = cmd.plan ||
		(cmd.decode && (is_end || (do_conv && !c_num)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LIT;
			flags_q <= '0;
			width_q <= '0;
			prec_q  <= '0;
			pg_q    <= 1'b0;
			lm_q    <= LM_NONE;
		end else if (clear_spec) begin
			phase_q <= PH_LIT;
			flags_q <= '0;
			width_q <= '0;
			prec_q  <= '0;
			pg_q    <= 1'b0;
			lm_q    <= LM_NONE;
		end else if (cmd.decode && !do_conv) begin
			phase_q <= phase_n;
			flags_q <= flags_n;
			width_q <= width_n;
			prec_q  <= prec_n;
			pg_q    <= pg_n;
			lm_q    <= lm_n;
		end
	end

	// Item capture and digit generation.
	logic [79:0] bcd_adj;
	logic        scan_more;

	always_comb begin
		for (int i = 0; i < 20; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
				: bcd_q[4*i +: 4];
		end
		scan_more = (dcnt_q > DCW'(1)) && (digs_q[DIGW-1 -: 4] == 4'd0);
	end

	// Segmented output.
	logic [FW-1:0] cur_cnt;
	logic          out_free, fire, nul_fire;
	logic [7:0]    fire_char;

	assign cur_cnt   = seg_cnt_q[seg_q];
	assign out_free  = !out_valid || out_ready;
	assign fire      = cmd.emit && (rem_q != '0) && (cur_cnt != '0) && out_free;
	assign nul_fire  = fire && endi_q && (rem_q == FW'(1));
	assign fire_char = (seg_q == SEG_DIGITS) ? hex_char(digs_q[DIGW-1 -: 4], upper_q)
		: seg_char_q[seg_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q   <= format_char;
			arg_q <= arg_value;
			end_q <= end_of_format;
		end
		if (cmd.decode) begin
			uv_q       <= uv_d;
			uvz_q      <= (uv_d == 64'd0);
			upper_q    <= (c_q == CH_UX);
			base16_q   <= c_b16;
			sign_q     <= sign_d;
			bcd_q      <= '0;
			conv_cnt_q <= '0;
			digs_q     <= digs_d;
			dcnt_q     <= DCW'(NDIG);
		end
		if (cmd.conv) begin
			bcd_q      <= {bcd_adj[78:0], uv_q[63]};
			uv_q       <= {uv_q[62:0], 1'b0};
			conv_cnt_q <= conv_cnt_q + 6'd1;
			if (sts.conv_done) digs_q <= {8'd0, bcd_adj[78:0], uv_q[63]};
		end
		if (cmd.scan && scan_more) begin
			digs_q <= {digs_q[DIGW-5:0], 4'd0};
			dcnt_q <= dcnt_q - DCW'(1);
		end
		if (cmd.decode || cmd.plan) begin
			seg_cnt_q  <= seg_cnt_d;
			seg_char_q <= seg_char_d;
		end else if (fire) begin
			seg_cnt_q[seg_q] <= cur_cnt - FW'(1);
			if (seg_q == SEG_DIGITS) digs_q <= {digs_q[DIGW-5:0], 4'd0};
		end
		if (fire) begin
			out_char   <= fire_char;
			last       <= (rem_q == FW'(1));
			char_total <= nul_fire ? written_q : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= '0;
			rem_q     <= '0;
			endi_q    <= 1'b0;
			written_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.decode || cmd.plan) begin
				seg_q  <= '0;
				rem_q  <= rem_d;
				endi_q <= cmd.decode && is_end;
			end else if (cmd.emit && rem_q != '0) begin
				if (cur_cnt == '0) seg_q <= seg_q + SEGW'(1);
				else if (fire) rem_q <= rem_q - FW'(1);
			end
			if (nul_fire) written_q <= '0;
			else if (fire && written_q != 16'hFFFF) written_q <= written_q + 16'd1;
			if (fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	assign sts.dec_number  = c_num && do_conv && !is_end;
	assign sts.dec_decimal = !c_b16 && !c_b8;
	assign sts.conv_done   = (conv_cnt_q == 6'd63);
	assign sts.scan_done   = !scan_more;
	assign sts.emit_done   = (rem_q == '0);

endmodule

// File: sv/printf_integer_formatter.sv
`timescale 1ns / 1ps
// An item is captured when it is accepted and is decoded in the next cycle;
// the output phase then emits each result character, steps over empty
// segments and closes the item, and it waits on any output stalls.
// Numbers add a leading-digit scan and a planning step; decimal numbers
// first pass through a shift-and-add-3 conversion of the argument.
// One item is in work at a time. Reset clears the parser state and the count.
// ----------------------------------------------------------------------------
// printf_integer_formatter
// Streams a printf format string and emits the formatted integer output.
// ----------------------------------------------------------------------------
module printf_integer_formatter import pif_pkg::*; #(
	parameter int MAX_FIELD = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  format_char,
	input  logic [63:0] arg_value,
	input  logic        end_of_format,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last,
	output logic [15:0] char_total
);

	cmd_t cmd;
	sts_t sts;

	pif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pif_dp #(
		.MAX_FIELD (MAX_FIELD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.format_char   (format_char),
		.arg_value     (arg_value),
		.end_of_format (end_of_format),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.last          (last),
		.char_total    (char_total)
	);

endmodule
